// File: rtl/core/fri_pkg.sv
// ----------------------------------------------------------------------------
// fri_pkg
// Shared types, constants and the CORDIC arctangent table of the fringe
// rotation and integration core.
// ----------------------------------------------------------------------------
package fri_pkg;

  localparam int MAX_CHANNELS = 4096;
  localparam int MAX_TIMES    = 4096;
  localparam int ROT_STEPS    = 16;
  localparam int VEC_STEPS    = 30;
  localparam int DIV_STEPS    = 60;
  localparam int QUEUE_DEPTH  = 4;
  localparam int INV_GAIN     = 39797;

  localparam logic [2:0] REG_DELAY_STEP = 3'd0;
  localparam logic [2:0] REG_RATE_BASE  = 3'd1;
  localparam logic [2:0] REG_RATE_SLOPE = 3'd2;
  localparam logic [2:0] REG_ACCEL_STEP = 3'd3;
  localparam logic [2:0] REG_SPEC_COUNT = 3'd4;
  localparam logic [2:0] REG_TIME_COUNT = 3'd5;

  typedef struct packed {
    logic signed [15:0] vis_re;
    logic signed [15:0] vis_im;
  } sample_t;

  typedef struct packed {
    logic        [15:0] amplitude;
    logic signed [15:0] phase_out;
    logic signed [55:0] sum_re;
    logic signed [55:0] sum_im;
  } result_t;

  typedef struct packed {
    logic signed [15:0] vis_re;
    logic signed [15:0] vis_im;
    logic        [31:0] phase;
    logic               last;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  typedef struct packed {
    logic [31:0] delay_step;
    logic [31:0] rate_base;
    logic [31:0] rate_slope;
    logic [31:0] accel_step;
    logic [12:0] n_eff;
    logic [12:0] t_eff;
  } cfg_t;

  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051D;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2E;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000028;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000002;
      5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/fri_front.sv
// ----------------------------------------------------------------------------
// fri_front
// Accepts samples, tracks the window position and computes the fringe phase
// of each sample before handing it to the queue.
// ----------------------------------------------------------------------------
module fri_front (
  input  logic             clk,
  input  logic             rst,
  input  fri_pkg::cfg_t    cfg,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  fri_pkg::sample_t sample,
  input  fri_pkg::qstat_t  qstat,
  output logic             push,
  output fri_pkg::job_t    push_job
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_MUL  = 3'd1;
  localparam logic [2:0] F_SUM  = 3'd2;
  localparam logic [2:0] F_MUL2 = 3'd3;
  localparam logic [2:0] F_PUSH = 3'd4;

  logic [2:0]       state;
  logic [11:0]      chan_pos;
  logic [11:0]      time_pos;
  fri_pkg::sample_t smp;
  logic             last;
  logic [11:0]      chan_cur;
  logic [31:0]      dk32, dt32;
  logic [31:0]      p_delay, p_slope, dt2, s_rate, p_rate, p_accel;

  logic             accept;
  logic [12:0]      chan_inc, time_inc;
  logic [13:0]      dk, dt;

  assign sample_stall = (state != F_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign chan_inc     = {1'b0, chan_pos} + 13'd1;
  assign time_inc     = {1'b0, time_pos} + 13'd1;
  assign dk           = {2'b00, chan_pos} - {2'b00, cfg.n_eff[12:1]};
  assign dt           = {2'b00, time_pos} - {2'b00, cfg.t_eff[12:1]};

  assign push            = (state == F_PUSH) && !qstat.full;
  assign push_job.vis_re = smp.vis_re;
  assign push_job.vis_im = smp.vis_im;
  assign push_job.phase  = p_delay + p_rate + p_accel;
  assign push_job.last   = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_IDLE;
      chan_pos <= '0;
      time_pos <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            state <= F_MUL;
            if (chan_inc >= cfg.n_eff) begin
              chan_pos <= '0;
              if (time_inc >= cfg.t_eff) begin
                time_pos <= '0;
              end else begin
                time_pos <= time_inc[11:0];
              end
            end else begin
              chan_pos <= chan_inc[11:0];
            end
          end
        end
        F_MUL:  state <= F_SUM;
        F_SUM:  state <= F_MUL2;
        F_MUL2: state <= F_PUSH;
        F_PUSH: begin
          if (push) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // Phase products wrap modulo one turn, so only the low 32 bits are kept.
  always_ff @(posedge clk) begin
    if (accept) begin
      smp      <= sample;
      last     <= (chan_inc >= cfg.n_eff) && (time_inc >= cfg.t_eff);
      chan_cur <= chan_pos;
      dk32     <= {{18{dk[13]}}, dk};
      dt32     <= {{18{dt[13]}}, dt};
    end
    if (state == F_MUL) begin
      p_delay <= cfg.delay_step * dk32;
      p_slope <= cfg.rate_slope * {20'b0, chan_cur};
      dt2     <= dt32 * dt32;
    end
    if (state == F_SUM) begin
      s_rate <= cfg.rate_base + p_slope;
    end
    if (state == F_MUL2) begin
      p_rate  <= dt32 * s_rate;
      p_accel <= cfg.accel_step * dt2;
    end
  end

endmodule

// File: rtl/core/fri_queue.sv
// ----------------------------------------------------------------------------
// fri_queue
// Short register queue that decouples the phase front end from the back end.
// ----------------------------------------------------------------------------
module fri_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fri_pkg::job_t   push_job,
  input  logic            pop,
  output fri_pkg::job_t   head,
  output fri_pkg::qstat_t qstat
);

  localparam int DEPTH = fri_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  fri_pkg::job_t   slots [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [PW:0]     count;

  assign head        = slots[rd_ptr];
  assign qstat.empty = (count == '0);
  assign qstat.full  = (count == (PW+1)'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

// File: rtl/core/fri_back.sv
// ----------------------------------------------------------------------------
// fri_back
// Derotates each queued sample with a CORDIC, accumulates it and, at the end
// of a window, finds magnitude and phase of the sums.
// ----------------------------------------------------------------------------
module fri_back (
  input  logic             clk,
  input  logic             rst,
  input  fri_pkg::cfg_t    cfg,
  input  fri_pkg::qstat_t  qstat,
  input  fri_pkg::job_t    head,
  output logic             pop,
  output logic             res_valid,
  input  logic             res_stall,
  output fri_pkg::result_t res
);

  localparam logic [3:0] B_IDLE  = 4'd0;
  localparam logic [3:0] B_ROT   = 4'd1;
  localparam logic [3:0] B_MUL   = 4'd2;
  localparam logic [3:0] B_ACC   = 4'd3;
  localparam logic [3:0] B_VINIT = 4'd4;
  localparam logic [3:0] B_VEC   = 4'd5;
  localparam logic [3:0] B_DPREP = 4'd6;
  localparam logic [3:0] B_DIV   = 4'd7;
  localparam logic [3:0] B_AMP   = 4'd8;
  localparam logic [3:0] B_OUT   = 4'd9;

  localparam logic signed [17:0] GAIN_S = 18'(fri_pkg::INV_GAIN);

  logic [3:0]         state;
  logic [5:0]         step;
  logic               cur_last;
  logic signed [27:0] xr, yr;
  logic signed [32:0] zr;
  logic signed [44:0] pre, pim;
  logic signed [55:0] acc_re, acc_im;
  logic signed [59:0] xv, yv;
  logic [31:0]        zv;
  logic               zero_sum;
  logic [24:0]        nt;
  logic [59:0]        dvd, quo;
  logic [25:0]        rem;
  logic [47:0]        ap;

  logic signed [27:0] re256, im256, x0, y0;
  logic signed [44:0] rre, rim;
  logic signed [59:0] sx, sy;
  logic [25:0]        trial;
  logic [31:0]        zrnd;
  logic [15:0]        amp;
  logic               take;

  assign pop   = (state == B_IDLE) && !qstat.empty;
  assign re256 = {{4{head.vis_re[15]}}, head.vis_re, 8'b0};
  assign im256 = {{4{head.vis_im[15]}}, head.vis_im, 8'b0};
  assign rre   = pre + 45'sd8388608;
  assign rim   = pim + 45'sd8388608;
  assign sx    = {{4{acc_re[55]}}, acc_re};
  assign sy    = {{4{acc_im[55]}}, acc_im};
  assign trial = {rem[24:0], dvd[59]};
  assign zrnd  = zv + 32'h00008000;
  assign amp   = ((|quo[59:32]) || (|ap[47:32])) ? 16'hFFFF : ap[31:16];
  assign take  = (state == B_OUT) && (!res_valid || !res_stall);

  // Exact quarter-turn pre-rotation selected by the top two phase bits.
  always_comb begin
    case (head.phase[31:30])
      2'd0:    begin x0 = re256;  y0 = im256;  end
      2'd1:    begin x0 = im256;  y0 = -re256; end
      2'd2:    begin x0 = -re256; y0 = -im256; end
      default: begin x0 = -im256; y0 = re256;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      step      <= '0;
      acc_re    <= '0;
      acc_im    <= '0;
      res_valid <= 1'b0;
    end else begin
      if (take) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (pop) begin
            step  <= '0;
            state <= B_ROT;
          end
        end
        B_ROT: begin
          step <= step + 6'd1;
          if (step == 6'(fri_pkg::ROT_STEPS - 1)) begin
            state <= B_MUL;
          end
        end
        B_MUL: state <= B_ACC;
        B_ACC: begin
          acc_re <= acc_re + {{35{rre[44]}}, rre[44:24]};
          acc_im <= acc_im + {{35{rim[44]}}, rim[44:24]};
          state  <= cur_last ? B_VINIT : B_IDLE;
        end
        B_VINIT: begin
          step  <= '0;
          state <= B_VEC;
        end
        B_VEC: begin
          step <= step + 6'd1;
          if (step == 6'(fri_pkg::VEC_STEPS - 1)) begin
            state <= B_DPREP;
          end
        end
        B_DPREP: begin
          step  <= '0;
          state <= B_DIV;
        end
        B_DIV: begin
          step <= step + 6'd1;
          if (step == 6'(fri_pkg::DIV_STEPS - 1)) begin
            state <= B_AMP;
          end
        end
        B_AMP: state <= B_OUT;
        B_OUT: begin
          if (take) begin
            acc_re    <= '0;
            acc_im    <= '0;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_last <= head.last;
      xr       <= x0;
      yr       <= y0;
      zr       <= -$signed({3'b000, head.phase[29:0]});
    end
    if (state == B_ROT) begin
      if (zr[32]) begin
        xr <= xr + (yr >>> step[4:0]);
        yr <= yr - (xr >>> step[4:0]);
        zr <= zr + $signed({1'b0, fri_pkg::atan_turns(step[4:0])});
      end else begin
        xr <= xr - (yr >>> step[4:0]);
        yr <= yr + (xr >>> step[4:0]);
        zr <= zr - $signed({1'b0, fri_pkg::atan_turns(step[4:0])});
      end
    end
    if (state == B_MUL) begin
      pre <= 45'(xr) * 45'(GAIN_S);
      pim <= 45'(yr) * 45'(GAIN_S);
    end
    if (state == B_VINIT) begin
      zero_sum <= (acc_re == '0) && (acc_im == '0);
      nt       <= 25'({12'b0, cfg.n_eff} * {12'b0, cfg.t_eff});
      if (sx[59]) begin
        xv <= -sx;
        yv <= -sy;
        zv <= 32'h80000000;
      end else begin
        xv <= sx;
        yv <= sy;
        zv <= 32'h00000000;
      end
    end
    if (state == B_VEC) begin
      if (!yv[59]) begin
        xv <= xv + (yv >>> step[4:0]);
        yv <= yv - (xv >>> step[4:0]);
        zv <= zv + fri_pkg::atan_turns(step[4:0]);
      end else begin
        xv <= xv - (yv >>> step[4:0]);
        yv <= yv + (xv >>> step[4:0]);
        zv <= zv - fri_pkg::atan_turns(step[4:0]);
      end
    end
    if (state == B_DPREP) begin
      dvd <= xv[59] ? '0 : xv;
      rem <= '0;
      quo <= '0;
    end
    if (state == B_DIV) begin
      dvd <= {dvd[58:0], 1'b0};
      if (trial >= {1'b0, nt}) begin
        rem <= trial - {1'b0, nt};
        quo <= {quo[58:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[58:0], 1'b0};
      end
    end
    if (state == B_AMP) begin
      ap <= {16'b0, quo[31:0]} * 48'(fri_pkg::INV_GAIN);
    end
    if (take) begin
      res.amplitude <= zero_sum ? 16'h0000 : amp;
      res.phase_out <= zero_sum ? 16'sh0000 : zrnd[31:16];
      res.sum_re    <= acc_re;
      res.sum_im    <= acc_im;
    end
  end

  a_rot_bound: assert property (@(posedge clk) disable iff (rst)
    state == B_ROT |-> step < 6'(fri_pkg::ROT_STEPS))
    else $error("rotation step count overran");

  a_res_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == B_OUT)
    else $error("result raised outside the output state");

  a_mid_window: assert property (@(posedge clk) disable iff (rst)
    (state == B_ACC && !cur_last) |=> state == B_IDLE)
    else $error("mid-window sample did not return to idle");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == B_DIV |-> nt != '0)
    else $error("divisor is zero");

endmodule

// File: rtl/core/fringe_rotate_integrate_core.sv
// ----------------------------------------------------------------------------
// fringe_rotate_integrate_core
// Fringe stopping and coherent integration of one window of visibilities.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                    Payload
//   sample    in         sample_valid / sample_stall  fri_pkg::sample_t
//   result    out        result_valid / result_stall  fri_pkg::result_t
//   config    in         APB psel/penable/pready      paddr, pwdata, prdata
//
// Each sample passes through the front end (phase products) and then the
// back end, whose 16-step rotation CORDIC sets the sustained sample rate;
// neither takes a new sample before it is through with the last. The last
// sample of a window adds the 30-step vectoring CORDIC and the 60-step divider.
// Reset is synchronous and active high; it clears sums and window position
// and sets the registers to their defaults. A stall on the result channel
// holds the finished transaction while the front keeps filling the queue.
//
module fringe_rotate_integrate_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  fri_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_stall,
  output fri_pkg::result_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [31:0] delay_step, rate_base, rate_slope, accel_step;
  logic [12:0] spec_count, time_count;
  logic [2:0]  reg_index;
  logic        wr_en;

  fri_pkg::cfg_t   cfg;
  fri_pkg::qstat_t qstat;
  fri_pkg::job_t   push_job, head;
  logic            push, pop;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign wr_en     = psel && penable && pwrite && pready;

  // Registers are written at the access phase of an APB write.
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_step <= '0;
      rate_base  <= '0;
      rate_slope <= '0;
      accel_step <= '0;
      spec_count <= 13'd1;
      time_count <= 13'd1;
    end else if (wr_en) begin
      case (reg_index)
        fri_pkg::REG_DELAY_STEP: delay_step <= pwdata;
        fri_pkg::REG_RATE_BASE:  rate_base  <= pwdata;
        fri_pkg::REG_RATE_SLOPE: rate_slope <= pwdata;
        fri_pkg::REG_ACCEL_STEP: accel_step <= pwdata;
        fri_pkg::REG_SPEC_COUNT: spec_count <= pwdata[12:0];
        fri_pkg::REG_TIME_COUNT: time_count <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      fri_pkg::REG_DELAY_STEP: prdata = delay_step;
      fri_pkg::REG_RATE_BASE:  prdata = rate_base;
      fri_pkg::REG_RATE_SLOPE: prdata = rate_slope;
      fri_pkg::REG_ACCEL_STEP: prdata = accel_step;
      fri_pkg::REG_SPEC_COUNT: prdata = {19'b0, spec_count};
      fri_pkg::REG_TIME_COUNT: prdata = {19'b0, time_count};
      default:                 prdata = '0;
    endcase
  end

  // A count of zero acts as one, and counts beyond the supported maximum
  // saturate there.
  assign cfg.delay_step = delay_step;
  assign cfg.rate_base  = rate_base;
  assign cfg.rate_slope = rate_slope;
  assign cfg.accel_step = accel_step;
  assign cfg.n_eff = (spec_count == '0) ? 13'd1 :
                     (spec_count > 13'(fri_pkg::MAX_CHANNELS)) ?
                     13'(fri_pkg::MAX_CHANNELS) : spec_count;
  assign cfg.t_eff = (time_count == '0) ? 13'd1 :
                     (time_count > 13'(fri_pkg::MAX_TIMES)) ?
                     13'(fri_pkg::MAX_TIMES) : time_count;

  fri_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .qstat        (qstat),
    .push         (push),
    .push_job     (push_job)
  );

  fri_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  fri_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .qstat     (qstat),
    .head      (head),
    .pop       (pop),
    .res_valid (result_valid),
    .res_stall (result_stall),
    .res       (result)
  );

endmodule

// File: tb/fringe_rotate_integrate_core_tb.sv
// ----------------------------------------------------------------------------
// fringe_rotate_integrate_core_tb
// Self-checking testbench for the fringe rotation and integration core.
// Drives sample transactions and register writes, predicts each window
// result with a bit-accurate behavioral copy of the core, and compares
// every result transaction field by field against that prediction.
// ----------------------------------------------------------------------------
module fringe_rotate_integrate_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CYCLE_LIMIT = 600000;
  // Samples can still be inside the core after the last window result: up
  // to the queue depth times the rotation time, plus the front end.
  localparam int     SETTLE      = 250;
  localparam longint GAIN_COMP   = 39797;

  // Arctangent of 2^-i in turns scaled by 2^32.
  localparam logic [31:0] ANGLE_STEP [30] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  logic             clk;
  logic             rst;
  logic             sample_valid;
  logic             sample_stall;
  fri_pkg::sample_t sample;
  logic             result_valid;
  logic             result_stall;
  fri_pkg::result_t result;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [4:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  fringe_rotate_integrate_core dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Free-running clock with an 8 ns period.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Shadow copy of the register file and the window state of the core.
  logic [31:0]        delay_step_q;
  logic [31:0]        rate_base_q;
  logic [31:0]        rate_slope_q;
  logic [31:0]        accel_step_q;
  logic [12:0]        spec_count_q;
  logic [12:0]        time_count_q;
  logic signed [55:0] sum_re_q;
  logic signed [55:0] sum_im_q;
  logic [31:0]        chan_pos_q;
  logic [31:0]        time_pos_q;

  fri_pkg::result_t window_results[$];
  int               error_count;
  int               cycle_count;

  // Stimulus shaping knobs shared between the test tasks and the receiver.
  bit      no_idle;
  bit      long_hold_req;

  // A count register of zero behaves as one, and anything above the
  // supported maximum saturates at that maximum.
  function automatic logic [31:0] clamp_count(input logic [12:0] c);
    if (c == 13'd0) begin
      return 32'd1;
    end
    if (c > 13'd4096) begin
      return 32'd4096;
    end
    return {19'd0, c};
  endfunction

  // Removes the fringe phase from one sample: an exact quarter-turn step
  // followed by a 16-step rotation CORDIC and the gain compensation.
  function automatic void derotate_sample(input logic signed [15:0] re,
                                          input logic signed [15:0] im,
                                          input logic [31:0] ph,
                                          output longint ore,
                                          output longint oim);
    longint a;
    longint b;
    longint x;
    longint y;
    longint z;
    longint nx;
    a = longint'(re) * 256;
    b = longint'(im) * 256;
    case (ph[31:30])
      2'd0: begin
        x = a;
        y = b;
      end
      2'd1: begin
        x = b;
        y = -a;
      end
      2'd2: begin
        x = -a;
        y = -b;
      end
      default: begin
        x = -b;
        y = a;
      end
    endcase
    z = -longint'({2'b00, ph[29:0]});
    for (int i = 0; i < 16; i++) begin
      if (z < 0) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(ANGLE_STEP[i]);
      end else begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(ANGLE_STEP[i]);
      end
      x = nx;
    end
    ore = (x * GAIN_COMP + (longint'(1) << 23)) >>> 24;
    oim = (y * GAIN_COMP + (longint'(1) << 23)) >>> 24;
  endfunction

  // Advances the shadow window by one accepted sample and queues the
  // window result when this sample closes the window.
  function automatic void integrate_sample(input fri_pkg::sample_t s);
    logic [31:0]            n;
    logic [31:0]            t;
    logic [31:0]            dk;
    logic [31:0]            dt;
    logic [31:0]            ph;
    longint                 dre;
    longint                 dim;
    longint                 x;
    longint                 y;
    longint                 nx;
    logic [31:0]            z;
    longint unsigned        m;
    longint unsigned        amp;
    fri_pkg::result_t       r;
    n  = clamp_count(spec_count_q);
    t  = clamp_count(time_count_q);
    dk = chan_pos_q - (n >> 1);
    dt = time_pos_q - (t >> 1);
    ph = delay_step_q * dk + dt * (rate_base_q + rate_slope_q * chan_pos_q)
       + accel_step_q * (dt * dt);
    derotate_sample(s.vis_re, s.vis_im, ph, dre, dim);
    sum_re_q = sum_re_q + dre[55:0];
    sum_im_q = sum_im_q + dim[55:0];

    chan_pos_q++;
    if (chan_pos_q < n) begin
      return;
    end
    chan_pos_q = 0;
    time_pos_q++;
    if (time_pos_q < t) begin
      return;
    end
    time_pos_q = 0;

    r.amplitude = '0;
    r.phase_out = '0;
    r.sum_re    = sum_re_q;
    r.sum_im    = sum_im_q;
    x = sum_re_q;
    y = sum_im_q;
    z = 32'd0;
    if (x != 0 || y != 0) begin
      // Fold into the right half plane, then vector onto the real axis.
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32'h80000000;
      end
      for (int i = 0; i < 30; i++) begin
        if (y >= 0) begin
          nx = x + (y >>> i);
          y  = y - (x >>> i);
          z  = z + ANGLE_STEP[i];
        end else begin
          nx = x - (y >>> i);
          y  = y + (x >>> i);
          z  = z - ANGLE_STEP[i];
        end
        x = nx;
      end
      if (x < 0) begin
        x = 0;
      end
      m = longint'(x) / (longint'(n) * longint'(t));
      if (m >= 64'h1_0000_0000) begin
        amp = 65535;
      end else begin
        amp = (m * 39797) >> 16;
        if (amp > 65535) begin
          amp = 65535;
        end
      end
      r.amplitude = amp[15:0];
      z           = z + 32'h8000;
      r.phase_out = z[31:16];
    end
    window_results.push_back(r);
    sum_re_q = '0;
    sum_im_q = '0;
  endfunction

  // Picks an idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 55) begin
      return 0;
    end
    if (p < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 45);
  endfunction

  // Sends one sample transaction. Called at a falling edge; valid stays high
  // into the next transaction when no gap follows.
  task automatic send_sample(input fri_pkg::sample_t s);
    int gap;
    sample_valid = 1'b1;
    sample       = s;
    do begin
      @(posedge clk);
    end while (sample_stall);
    integrate_sample(s);
    @(negedge clk);
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      sample_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_parts(input logic [15:0] re, input logic [15:0] im);
    fri_pkg::sample_t s;
    s.vis_re = re;
    s.vis_im = im;
    send_sample(s);
  endtask

  function automatic fri_pkg::sample_t random_sample();
    fri_pkg::sample_t s;
    int               p;
    p = $urandom_range(9);
    if (p < 6) begin
      s = $urandom;
    end else begin
      // Small values keep the sums near zero and exercise the sign handling.
      s.vis_re = 16'($signed($urandom_range(0, 16)) - 8);
      s.vis_im = 16'($signed($urandom_range(0, 16)) - 8);
    end
    return s;
  endfunction

  // Register write through the APB port: a setup cycle, then an access cycle.
  // The shadow copy follows at the edge where the write lands.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    case (idx)
      fri_pkg::REG_DELAY_STEP: delay_step_q = value;
      fri_pkg::REG_RATE_BASE:  rate_base_q  = value;
      fri_pkg::REG_RATE_SLOPE: rate_slope_q = value;
      fri_pkg::REG_ACCEL_STEP: accel_step_q = value;
      fri_pkg::REG_SPEC_COUNT: spec_count_q = value[12:0];
      fri_pkg::REG_TIME_COUNT: time_count_q = value[12:0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Waits until every predicted result has come out, then lets any partial
  // window samples still inside the core drain before the next write.
  task automatic wait_quiet();
    sample_valid = 1'b0;
    while (window_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_phase_regs(input logic [31:0] d, input logic [31:0] rb,
                                  input logic [31:0] rs, input logic [31:0] ac);
    write_reg(fri_pkg::REG_DELAY_STEP, d);
    write_reg(fri_pkg::REG_RATE_BASE, rb);
    write_reg(fri_pkg::REG_RATE_SLOPE, rs);
    write_reg(fri_pkg::REG_ACCEL_STEP, ac);
  endtask

  // Reset defaults give one-sample windows with zero phase, so each sample
  // comes straight back; the extremes of both parts and the zero-sum case.
  task automatic test_defaults_extremes();
    send_parts(16'h0000, 16'h0000);
    send_parts(16'h7FFF, 16'h7FFF);
    send_parts(16'h8000, 16'h8000);
    send_parts(16'h8000, 16'h0000);
    send_parts(16'h0000, 16'h7FFF);
    send_parts(16'h0001, 16'hFFFF);
    send_parts(16'hFFFF, 16'h8000);
    wait_quiet();
  endtask

  // Extreme phase slopes over a small window covering all quadrants.
  task automatic test_phase_extremes();
    write_phase_regs(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF);
    write_reg(fri_pkg::REG_SPEC_COUNT, 32'd3);
    write_reg(fri_pkg::REG_TIME_COUNT, 32'd2);
    send_parts(16'h7FFF, 16'h0000);
    send_parts(16'h8000, 16'h7FFF);
    send_parts(16'h1234, 16'hEDCB);
    send_parts(16'h7FFF, 16'h7FFF);
    send_parts(16'h8000, 16'h8000);
    send_parts(16'h0000, 16'h8000);
    wait_quiet();
    write_phase_regs(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000);
    write_reg(fri_pkg::REG_SPEC_COUNT, 32'd2);
    write_reg(fri_pkg::REG_TIME_COUNT, 32'd1);
    send_parts(16'h4000, 16'hC000);
    send_parts(16'h8000, 16'h7FFF);
    wait_quiet();
  endtask

  // Count registers written as zero behave as a count of one.
  task automatic test_zero_counts();
    write_reg(fri_pkg::REG_SPEC_COUNT, 32'd0);
    write_reg(fri_pkg::REG_TIME_COUNT, 32'd0);
    send_parts(16'h0100, 16'hFF00);
    send_parts(16'h7FFF, 16'h8000);
    wait_quiet();
  endtask

  // Oversized counts saturate at the maximum, which moves the window center.
  // A smaller count written mid-window then closes the row or the window on
  // the next sample, since the position is already past the new count.
  task automatic test_saturate_and_shrink();
    write_phase_regs(32'h00010000, 32'h00200000, 32'h00003000, 32'h00000100);
    write_reg(fri_pkg::REG_SPEC_COUNT, 32'h1FFF);
    write_reg(fri_pkg::REG_TIME_COUNT, 32'd1);
    send_parts(16'h2000, 16'h1000);
    send_parts(16'hE000, 16'h3000);
    send_parts(16'h7FFF, 16'h0001);
    wait_quiet();
    write_reg(fri_pkg::REG_SPEC_COUNT, 32'd2);
    send_parts(16'h0400, 16'hFC00);
    wait_quiet();
    write_reg(fri_pkg::REG_SPEC_COUNT, 32'd1);
    write_reg(fri_pkg::REG_TIME_COUNT, 32'd4096);
    send_parts(16'h0FFF, 16'hF001);
    send_parts(16'h5555, 16'hAAAA);
    wait_quiet();
    write_reg(fri_pkg::REG_TIME_COUNT, 32'd1);
    send_parts(16'h0001, 16'h0001);
    wait_quiet();
  endtask

  // Random register settings with small windows so results stay frequent,
  // and random sample content in each window.
  task automatic test_random_windows();
    int sent;
    int n;
    int p;
    sent = 0;
    while (sent < 360) begin
      p = $urandom_range(9);
      if (p == 0) begin
        write_phase_regs(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
      end else if (p < 4) begin
        // Slow fringes keep the coherent sums large.
        write_phase_regs(32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)),
                         32'($signed($urandom_range(0, 1 << 22)) - (1 << 21)),
                         32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)),
                         32'($signed($urandom_range(0, 1 << 16)) - (1 << 15)));
      end else begin
        write_phase_regs($urandom, $urandom, $urandom, $urandom);
      end
      write_reg(fri_pkg::REG_SPEC_COUNT, 32'($urandom_range(1, 5)));
      write_reg(fri_pkg::REG_TIME_COUNT, 32'($urandom_range(1, 4)));
      no_idle = ($urandom_range(4) == 0);
      n = $urandom_range(10, 40);
      for (int i = 0; i < n; i++) begin
        send_sample(random_sample());
      end
      sent += n;
      no_idle = 1'b0;
      wait_quiet();
    end
  endtask

  // The receiver holds off for a long stretch while samples keep coming, so
  // finished results back up and the core has to stall its input.
  task automatic test_backpressure();
    write_phase_regs($urandom, $urandom, $urandom, $urandom);
    write_reg(fri_pkg::REG_SPEC_COUNT, 32'd2);
    write_reg(fri_pkg::REG_TIME_COUNT, 32'd1);
    no_idle       = 1'b1;
    long_hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_sample(random_sample());
    end
    no_idle = 1'b0;
    wait_quiet();
  endtask

  // Receiver: stall runs of random length, mostly short, with a long hold
  // on request that is counted here in cycles.
  int stall_left;
  int hold_left;
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
      hold_left    <= 0;
    end else if (long_hold_req) begin
      long_hold_req <= 1'b0;
      hold_left     <= 700;
      result_stall  <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else if (no_idle) begin
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      result_stall <= ($urandom_range(2) == 0);
      stall_left   <= pick_gap();
    end
  end

  // Checker: each accepted result transaction is matched against the oldest
  // predicted window result.
  always @(posedge clk) begin
    fri_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (window_results.size() == 0) begin
        $display("%0t: unexpected result transaction %h", $time, result);
        error_count++;
      end else begin
        want = window_results.pop_front();
        if (result.amplitude !== want.amplitude) begin
          $display("%0t: amplitude expected %0d actual %0d", $time,
                   want.amplitude, result.amplitude);
          error_count++;
        end
        if (result.phase_out !== want.phase_out) begin
          $display("%0t: phase_out expected %0d actual %0d", $time,
                   want.phase_out, result.phase_out);
          error_count++;
        end
        if (result.sum_re !== want.sum_re) begin
          $display("%0t: sum_re expected %0d actual %0d", $time,
                   want.sum_re, result.sum_re);
          error_count++;
        end
        if (result.sum_im !== want.sum_im) begin
          $display("%0t: sum_im expected %0d actual %0d", $time,
                   want.sum_im, result.sum_im);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    sample_valid  = 1'b0;
    sample        = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    result_stall  = 1'b0;
    no_idle       = 1'b0;
    long_hold_req = 1'b0;
    error_count   = 0;
    cycle_count   = 0;
    delay_step_q  = '0;
    rate_base_q   = '0;
    rate_slope_q  = '0;
    accel_step_q  = '0;
    spec_count_q  = 13'd1;
    time_count_q  = 13'd1;
    sum_re_q      = '0;
    sum_im_q      = '0;
    chan_pos_q    = '0;
    time_pos_q    = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_defaults_extremes();
    test_phase_extremes();
    test_zero_counts();
    test_saturate_and_shrink();
    test_backpressure();
    test_random_windows();

    wait_quiet();
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
